[hw/rtl/assert_macros.svh]
// Assertion helper macros for the search table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/tlbs_pkg.sv]
// Shared types and constants for the search table block.
// No dependencies.
package tlbs_pkg;

    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;
    localparam int PROBE_W     = 11;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - PROBE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_BINARY = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [PROBE_W-1:0] probe_count;
    } t_result;

endpackage

[hw/rtl/tlbs_mem.sv]
// Simple dual-port table memory, one write and one registered read port.
// Depends on nothing; sized by the top-level parameters.
module tlbs_mem #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32,
    parameter int AW          = 10
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/tlbs_engine.sv]
// Command decode, fill count and linear/binary search sequencer.
// Depends on tlbs_pkg; drives the ports of tlbs_mem.
module tlbs_engine #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32,
    parameter int AW          = 10,
    parameter int CW          = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tlbs_pkg::t_kind       i_kind,
    input  logic [tlbs_pkg::VALUE_W-1:0] i_value,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output tlbs_pkg::t_result     o_res,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [DATA_WIDTH-1:0] o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [DATA_WIDTH-1:0] i_rd_data
);
    import tlbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_HOLD
    } t_state;

    localparam logic [CW-1:0] DEPTH_CW = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_CW   = CW'(1);

    t_state                r_state;
    logic [CW-1:0]         r_fill;
    logic [DATA_WIDTH-1:0] r_key;
    logic                  r_bin;
    logic [CW-1:0]         r_addr;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi;
    logic [CW-1:0]         r_probes;
    t_result               r_res;

    logic [DATA_WIDTH+VALUE_W-1:0] w_value_ext;
    logic [DATA_WIDTH-1:0]         w_key;
    logic                          w_accept;
    logic                          w_search;
    logic                          w_full;
    logic [CW-1:0]                 w_first_addr;
    logic                          w_eq;
    logic                          w_lt;
    logic [CW-1:0]                 w_probes_nx;
    logic [CW-1:0]                 w_idx_nx;
    logic [CW-1:0]                 n_lo;
    logic [CW-1:0]                 n_hi;
    logic [CW-1:0]                 w_mid_nx;
    logic [CW-1:0]                 n_addr;
    logic                          w_more;
    logic [CW+POS_W-1:0]           w_pos_ext;
    logic [CW+PROBE_W-1:0]         w_probe_ext;

    // key truncated to DATA_WIDTH bits after sign extension
    assign w_value_ext = {{DATA_WIDTH{i_value[VALUE_W-1]}}, i_value};
    assign w_key       = w_value_ext[DATA_WIDTH-1:0];

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_search = (i_kind == KIND_LINEAR) || (i_kind == KIND_BINARY);
    assign w_full   = (r_fill == DEPTH_CW);

    assign w_first_addr = (i_kind == KIND_BINARY) ? ((r_fill - ONE_CW) >> 1) : '0;

    // probe step: compare, then next index in the same cycle
    assign w_eq        = (i_rd_data == r_key);
    assign w_lt        = ($signed(i_rd_data) < $signed(r_key));
    assign w_probes_nx = r_probes + ONE_CW;
    assign w_idx_nx    = r_addr + ONE_CW;
    assign n_lo        = w_lt ? w_idx_nx : r_lo;
    assign n_hi        = w_lt ? r_hi : r_addr;
    assign w_mid_nx    = n_lo + ((n_hi - n_lo - ONE_CW) >> 1);
    assign n_addr      = r_bin ? w_mid_nx : w_idx_nx;
    assign w_more      = r_bin ? (n_lo < n_hi) : (w_idx_nx < r_fill);

    assign w_pos_ext   = {{POS_W{1'b0}}, r_addr};
    assign w_probe_ext = {{PROBE_W{1'b0}}, w_probes_nx};

    // appends write at issue; searches never overlap them
    assign o_wr_en   = w_accept && (i_kind == KIND_APPEND) && !w_full;
    assign o_wr_addr = r_fill[AW-1:0];
    assign o_wr_data = w_key;

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = w_first_addr[AW-1:0];
        if (r_state == S_IDLE) begin
            o_rd_en = w_accept && w_search && (r_fill != '0);
        end else if (r_state == S_PROBE) begin
            o_rd_en   = !w_eq && w_more;
            o_rd_addr = n_addr[AW-1:0];
        end
    end

    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_kind)
                            KIND_APPEND: begin
                                if (!w_full) begin
                                    r_fill <= r_fill + ONE_CW;
                                end
                            end
                            KIND_CLEAR: begin
                                r_fill <= '0;
                            end
                            KIND_LINEAR, KIND_BINARY: begin
                                r_key    <= w_key;
                                r_bin    <= (i_kind == KIND_BINARY);
                                r_probes <= '0;
                                r_lo     <= '0;
                                r_hi     <= r_fill;
                                r_addr   <= w_first_addr;
                                if (r_fill == '0) begin
                                    r_res   <= '0;
                                    r_state <= S_HOLD;
                                end else begin
                                    r_state <= S_PROBE;
                                end
                            end
                            default: begin
                                r_fill <= r_fill;
                            end
                        endcase
                    end
                end
                S_PROBE: begin
                    r_probes <= w_probes_nx;
                    if (w_eq) begin
                        r_res.found       <= 1'b1;
                        r_res.position    <= w_pos_ext[POS_W-1:0];
                        r_res.probe_count <= w_probe_ext[PROBE_W-1:0];
                        r_state           <= S_HOLD;
                    end else if (w_more) begin
                        r_addr <= n_addr;
                        r_lo   <= n_lo;
                        r_hi   <= n_hi;
                    end else begin
                        r_res.found       <= 1'b0;
                        r_res.position    <= '0;
                        r_res.probe_count <= w_probe_ext[PROBE_W-1:0];
                        r_state           <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/tlbs_out_stage.sv]
// Output register for search results; packs the master-side beat.
// Depends on tlbs_pkg.
module tlbs_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  tlbs_pkg::t_result                  i_res,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tlbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // position, probe_count, pad
    output logic [0:0]                         m_axis_tuser   // found
);
    import tlbs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_res.probe_count, r_res.position};
    assign m_axis_tuser  = r_res.found;

endmodule

[hw/rtl/table_linear_binary_search.sv]
// Search table: loads signed words and answers linear or binary searches.
// Slave beat: tuser = kind (0 append, 1 linear, 2 binary, 3 clear), tdata = value.
// Master beat: one per search; tuser = found, tdata = position and probe count.
// Appends land after the last entry; appends into a full table are dropped.
// Clear empties the table; appends and clears give no beat.
// Appends and clears leave the engine idle and ready for the next beat. A search
// issues one memory read per probe, one per cycle, through the registered read
// port of the table memory; the next beat is taken only after its result has
// left the engine for the output register. Binary search probes at most
// floor(log2(count)) + 1 entries, linear search up to count. An empty-table
// search reads no entry and gives found, position and probe count zero.
// Reset clears the fill count and the output register's valid flag; the memory itself is
// not cleared and needs no clearing pass.
// The result sits in an output register; while the receiver stalls, the block
// keeps accepting and runs the next item, and holds a later result inside the
// engine until the register frees up.
// Depends on tlbs_pkg, tlbs_mem, tlbs_engine, tlbs_out_stage, assert_macros.svh.
`include "assert_macros.svh"

module table_linear_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tlbs_pkg::VALUE_W-1:0]     s_axis_tdata,  // value
    input  logic [tlbs_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tlbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // position, probe_count, pad
    output logic [0:0]                       m_axis_tuser   // found
);
    import tlbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_res_valid;
    logic                  w_res_ready;
    t_result               w_res;
    t_kind                 w_kind;

    assign w_kind = t_kind'(s_axis_tuser);

    tlbs_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tlbs_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (w_kind),
        .i_value     (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    tlbs_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_res_valid),
        .o_ready       (w_res_ready),
        .i_res         (w_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a table write and a probe read never share a cycle
    `ASSERT_IMPLIES(a_no_rw_overlap, i_clk, i_rst_n, w_wr_en, !w_rd_en)
    // a pending result blocks new input
    `ASSERT_IMPLIES(a_hold_blocks_input, i_clk, i_rst_n, w_res_valid, !s_axis_tready)
    // a result handed over shows up on the master side next cycle
    `ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_res_valid && w_res_ready, m_axis_tvalid)

endmodule

[test/table_linear_binary_search_test.sv]
// Testbench for table_linear_binary_search: directed and random append, search and clear beats.
// Results are predicted by a behavioral table model and compared field by field in order.
// Depends on tlbs_pkg and the table_linear_binary_search RTL.
`timescale 1ns / 100ps

module table_linear_binary_search_test;
    import tlbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 340;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'h7fff_ffff;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [VALUE_W-1:0]     s_axis_tdata;   // value
    logic [KIND_W-1:0]      s_axis_tuser;   // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // position, probe_count, pad
    logic [0:0]             m_axis_tuser;   // found

    logic signed [VALUE_W-1:0] table_words [TABLE_DEPTH];
    int                        table_fill;
    t_result                   expected_results [$];
    int                        error_count;
    int                        cycle_count;
    int                        beat_count;
    bit                        no_idle;

    table_linear_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at beat %0d: %s expected %0d got %0d", beat_count, what, want, got);
        error_count++;
    endtask

    // table model: updates the fill and word store, queues a result for searches
    task automatic table_search_step(input t_kind kind, input logic signed [VALUE_W-1:0] key);
        t_result res;
        int      idx;
        int      lo;
        int      hi;
        int      mid;
        bit      done;
        res = '0;
        done = 1'b0;
        case (kind)
            KIND_APPEND: begin
                if (table_fill < TABLE_DEPTH) begin
                    table_words[table_fill] = key;
                    table_fill++;
                end
            end
            KIND_CLEAR: begin
                table_fill = 0;
            end
            KIND_LINEAR: begin
                for (idx = 0; idx < table_fill && !done; idx++) begin
                    res.probe_count = res.probe_count + 1'b1;
                    if (table_words[idx] == key) begin
                        res.found = 1'b1;
                        res.position = POS_W'(idx);
                        done = 1'b1;
                    end
                end
                expected_results.insert(expected_results.size(), res);
            end
            KIND_BINARY: begin
                lo = 0;
                hi = table_fill - 1;
                while (lo <= hi && !done) begin
                    mid = lo + (hi - lo) / 2;
                    res.probe_count = res.probe_count + 1'b1;
                    if (table_words[mid] == key) begin
                        res.found = 1'b1;
                        res.position = POS_W'(mid);
                        done = 1'b1;
                    end else if (table_words[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                expected_results.insert(expected_results.size(), res);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beat_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat, found", 0, m_axis_tuser[0]);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser[0] !== want.found)
                    report_mismatch("found", want.found, m_axis_tuser[0]);
                if (m_axis_tdata[POS_W-1:0] !== want.position)
                    report_mismatch("position", want.position, m_axis_tdata[POS_W-1:0]);
                if (m_axis_tdata[POS_W+PROBE_W-1:POS_W] !== want.probe_count)
                    report_mismatch("probe_count", want.probe_count,
                                    m_axis_tdata[POS_W+PROBE_W-1:POS_W]);
            end
        end
    end

    task automatic send_beat(input t_kind kind, input logic signed [VALUE_W-1:0] key);
        while (!no_idle && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= key;
        do @(posedge i_clk); while (!s_axis_tready);
        table_search_step(kind, key);
    endtask

    // hold the sender until every queued result has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_empty_table();
        send_beat(KIND_LINEAR, 32'sd0);
        send_beat(KIND_BINARY, -32'sd1);
        wait_results_drained();
    endtask

    task automatic test_value_extremes();
        send_beat(KIND_APPEND, WORD_MIN);
        send_beat(KIND_APPEND, -32'sd1);
        send_beat(KIND_APPEND, 32'sd0);
        send_beat(KIND_APPEND, 32'sd1);
        send_beat(KIND_APPEND, WORD_MAX);
        send_beat(KIND_LINEAR, WORD_MIN);
        send_beat(KIND_LINEAR, WORD_MAX);
        send_beat(KIND_LINEAR, 32'sd2);
        send_beat(KIND_BINARY, WORD_MIN);
        send_beat(KIND_BINARY, WORD_MAX);
        send_beat(KIND_BINARY, 32'sd0);
        send_beat(KIND_BINARY, 32'sd5);
        send_beat(KIND_BINARY, WORD_MIN + 1);
        wait_results_drained();
    endtask

    task automatic test_unsorted_and_clear();
        send_beat(KIND_CLEAR, 32'sd0);
        send_beat(KIND_APPEND, 32'sd7);
        send_beat(KIND_APPEND, 32'sd3);
        send_beat(KIND_APPEND, 32'sd7);
        send_beat(KIND_LINEAR, 32'sd7);
        send_beat(KIND_BINARY, 32'sd7);
        send_beat(KIND_BINARY, 32'sd8);
        send_beat(KIND_CLEAR, 32'sd0);
        send_beat(KIND_LINEAR, 32'sd7);
        wait_results_drained();
    endtask

    task automatic test_full_table();
        int idx;
        send_beat(KIND_CLEAR, 32'sd0);
        for (idx = 0; idx < TABLE_DEPTH; idx++)
            send_beat(KIND_APPEND, idx * 4 - 2048);
        send_beat(KIND_APPEND, 32'sd9000);  // dropped: table full
        send_beat(KIND_LINEAR, 32'sd9000);
        send_beat(KIND_LINEAR, 32'sd2044);
        send_beat(KIND_BINARY, 32'sd2044);
        send_beat(KIND_BINARY, -32'sd2048);
        send_beat(KIND_BINARY, -32'sd2047);
        send_beat(KIND_BINARY, 32'sd1000);
        send_beat(KIND_CLEAR, 32'sd0);
        send_beat(KIND_BINARY, 32'sd0);
        wait_results_drained();
    endtask

    task automatic test_random_sets();
        logic signed [VALUE_W-1:0] set_words [$];
        logic signed [VALUE_W-1:0] key;
        longint                    acc;
        int                        sent;
        int                        set_size;
        int                        searches;
        int                        pick;
        int                        n;
        bit                        sorted_set;
        bit                        tight;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = (sent >= 100 && sent < 220);
            if ($urandom_range(99) < 90) begin
                send_beat(KIND_CLEAR, $urandom);
                set_words.delete();
                sent++;
            end
            set_size = ($urandom_range(19) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
            sorted_set = ($urandom_range(99) < 70);
            tight = ($urandom_range(99) < 30);
            acc = tight ? -8 : longint'($signed($urandom));
            for (n = 0; n < set_size; n++) begin
                if (sorted_set) begin
                    acc = acc + (tight ? $urandom_range(0, 2) : $urandom_range(0, 1 << 24));
                    if (acc > WORD_MAX)
                        acc = WORD_MAX;
                    key = VALUE_W'(acc);
                end else begin
                    key = tight ? $signed(VALUE_W'($urandom_range(0, 15))) - 8 : $urandom;
                end
                send_beat(KIND_APPEND, key);
                set_words.insert(set_words.size(), key);
                sent++;
            end
            searches = $urandom_range(1, 8);
            for (n = 0; n < searches; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    key = $urandom;
                    send_beat(KIND_APPEND, key);
                    set_words.insert(set_words.size(), key);
                    sent++;
                end else if (pick < 7) begin
                    send_beat(KIND_CLEAR, 32'sd0);
                    set_words.delete();
                    sent++;
                end
                pick = $urandom_range(99);
                if (set_words.size() == 0 || pick < 20)
                    key = $urandom;
                else if (pick < 60)
                    key = set_words[$urandom_range(0, set_words.size() - 1)];
                else
                    key = set_words[$urandom_range(0, set_words.size() - 1)]
                          + (($urandom_range(1) == 1) ? 1 : -1);
                send_beat(($urandom_range(1) == 1) ? KIND_BINARY : KIND_LINEAR, key);
                sent++;
            end
            if ($urandom_range(19) == 0)
                wait_results_drained();
        end
        no_idle = 1'b0;
        wait_results_drained();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= KIND_APPEND;
        s_axis_tdata  <= '0;
        table_fill    = 0;
        error_count   = 0;
        cycle_count   = 0;
        beat_count    = 0;
        no_idle       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_value_extremes();
        test_unsorted_and_clear();
        test_full_table();
        test_random_sets();

        // a stray beat could take a full-table scan to show up
        repeat (TABLE_DEPTH + 50) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results still pending", 0, expected_results.size());
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tlbs_pkg.sv
hw/rtl/tlbs_mem.sv
hw/rtl/tlbs_engine.sv
hw/rtl/tlbs_out_stage.sv
hw/rtl/table_linear_binary_search.sv
test/table_linear_binary_search_test.sv
